// ----- rtl/core/tpag_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package tpag_pkg;

  localparam int MAX_EXTENT = 4096;
  localparam int ADDR_W     = 32;
  localparam int COORD_W    = $clog2(MAX_EXTENT);
  localparam int SIZE_W     = COORD_W + 1;
  localparam int AXES       = 4;
  localparam int MAP_W      = 8;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = ADDR_W;

  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 2 * ADDR_W;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_X   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Y   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Z   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_W   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_AXIS_MAP = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_STRIDE_1 = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_STRIDE_2 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_STRIDE_3 = 3'd7;

  // identity map: output axis a reads input axis a
  localparam logic [MAP_W-1:0] AXIS_MAP_RESET = 8'd228;

  typedef struct packed {
    logic [AXES-1:0][SIZE_W-1:0] size;
    logic [MAP_W-1:0]            axis_map;
  } tpag_cfg_t;

  // one walked element, input coordinates already routed through the axis map
  typedef struct packed {
    logic [ADDR_W-1:0]            dest;
    logic                         last_el;
    logic [AXES-1:0][COORD_W-1:0] ids;
  } tpag_elem_t;

  typedef struct packed {
    logic [ADDR_W-1:0] dest;
    logic              last_el;
    logic [ADDR_W-1:0] id0;
    logic [ADDR_W-1:0] p1;
    logic [ADDR_W-1:0] p2;
    logic [ADDR_W-1:0] p3;
  } tpag_prod_t;

endpackage

`default_nettype wire

// ----- rtl/core/tpag_walker.sv -----
`timescale 1ns / 1ps
`default_nettype none

module tpag_walker (
  input  wire                    clk,
  input  wire                    rst_n,
  input  tpag_pkg::tpag_cfg_t    cfg,
  input  wire                    load,
  input  wire                    accept,
  input  wire                    restart,
  output logic                   elem_valid,
  output tpag_pkg::tpag_elem_t   elem
);
  import tpag_pkg::*;

  logic [AXES-1:0][COORD_W-1:0] coord_r, coord_nxt;
  logic [ADDR_W-1:0]            dest_r, dest_nxt;
  logic                         done_r, done_nxt;
  logic                         a_valid_r;
  tpag_elem_t                   a_elem_r, elem_nxt;

  logic [AXES-1:0][SIZE_W-1:0]  eff;
  logic [AXES-1:0][COORD_W-1:0] cs;
  logic [AXES-1:0]              wrap;
  logic [AXES-1:0][COORD_W-1:0] bumped;
  logic [AXES-1:0][COORD_W-1:0] ids;
  logic [ADDR_W-1:0]            dest_start;
  logic                         done_start;
  logic                         zero;
  logic                         emit;
  logic                         last_el;
  logic                         carry;

  always_comb begin
    zero = 1'b0;
    for (int i = 0; i < AXES; i++) begin
      eff[i] = (cfg.size[i] > SIZE_W'(MAX_EXTENT)) ? SIZE_W'(MAX_EXTENT) : cfg.size[i];
      zero   = zero | (eff[i] == '0);
      cs[i]  = restart ? '0 : coord_r[i];
      // a coordinate at or past its extent counts as at its end
      wrap[i] = (SIZE_W'(cs[i]) + SIZE_W'(1)) >= eff[i];
    end
    dest_start = restart ? '0 : dest_r;
    done_start = restart ? zero : done_r;
    emit       = !done_start && !zero;
    last_el    = &wrap;

    carry = 1'b1;
    for (int i = 0; i < AXES; i++) begin
      bumped[i] = cs[i];
      if (carry) begin
        bumped[i] = wrap[i] ? '0 : cs[i] + COORD_W'(1);
      end
      carry = carry & wrap[i];
    end

    // lowest output axis wins on a repeated input axis
    ids = '0;
    for (int a = AXES - 1; a >= 0; a--) begin
      ids[cfg.axis_map[2*a +: 2]] = cs[a];
    end

    coord_nxt = cs;
    dest_nxt  = dest_start;
    done_nxt  = done_start;
    if (emit) begin
      dest_nxt = dest_start + ADDR_W'(1);
      if (last_el) begin
        done_nxt  = 1'b1;
        coord_nxt = '0;
      end else begin
        coord_nxt = bumped;
      end
    end

    elem_nxt.dest    = dest_start;
    elem_nxt.last_el = last_el;
    elem_nxt.ids     = ids;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coord_r   <= '0;
      dest_r    <= '0;
      done_r    <= 1'b1;
      a_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        coord_r <= coord_nxt;
        dest_r  <= dest_nxt;
        done_r  <= done_nxt;
      end
      if (load) begin
        a_valid_r <= accept && emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && accept && emit) begin
      a_elem_r <= elem_nxt;
    end
  end

  assign elem_valid = a_valid_r;
  assign elem       = a_elem_r;

endmodule

`default_nettype wire

// ----- rtl/core/tensor_permute_address_generator.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Permute address generator for a 4-D tensor (x fastest, then y, z, w).
// Input stream: one item per tick; in_tdata[0] = restart (1 starts a new walk
// at coordinate zero and emits that element on the same item, 0 advances).
// Output stream: one address pair per element; out_tdata holds the dense
// destination index (low word) and the mapped source index (high word);
// out_tlast marks the last element of the walk. Ticks after the walk is done,
// or while any size is zero, are consumed and give no result.
// Configuration: cfg_we/cfg_index/cfg_data write sizes, axis map and source
// strides; write only while no item is in flight.
// Pipeline: an accepted item passes through the walker register, the stride
// multiply register and the sum/output register before its result appears on
// out_tvalid.
// Throughput: one item per cycle while the output is not stalled; the walker
// updates its coordinates and each stage advances whenever the stage after
// it moves. When the receiver stalls, the output holds and the stages behind
// it fill; once all three hold an element, in_tready drops. Items that give
// no result are still taken while a stage is free.
// Reset: sizes and strides clear to zero, the axis map goes to identity and
// the walker idles until a restart.
module tensor_permute_address_generator (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                in_tvalid,
  output logic                               in_tready,
  input  wire  [tpag_pkg::IN_DATA_W-1:0]     in_tdata,   // [0] restart, rest zero
  output logic                               out_tvalid,
  input  wire                                out_tready,
  output logic [tpag_pkg::OUT_DATA_W-1:0]    out_tdata,  // {src_address, dest_address}
  output logic                               out_tlast,
  input  wire                                cfg_we,
  input  wire  [tpag_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire  [tpag_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import tpag_pkg::*;

  tpag_cfg_t                    cfg_r;
  logic [ADDR_W-1:0]            stride1_r, stride2_r, stride3_r;

  logic                         a_ready;
  logic                         a_valid;
  tpag_elem_t                   a_elem;
  logic                         in_accept;

  logic                         b_ready;
  logic                         b_valid_r;
  tpag_prod_t                   b_r;

  logic                         c_ready;
  logic                         c_valid_r;
  logic [OUT_DATA_W-1:0]        c_data_r;
  logic                         c_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.size     <= '0;
      cfg_r.axis_map <= AXIS_MAP_RESET;
      stride1_r      <= '0;
      stride2_r      <= '0;
      stride3_r      <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SIZE_X:   cfg_r.size[0]  <= cfg_data[SIZE_W-1:0];
        CFG_SIZE_Y:   cfg_r.size[1]  <= cfg_data[SIZE_W-1:0];
        CFG_SIZE_Z:   cfg_r.size[2]  <= cfg_data[SIZE_W-1:0];
        CFG_SIZE_W:   cfg_r.size[3]  <= cfg_data[SIZE_W-1:0];
        CFG_AXIS_MAP: cfg_r.axis_map <= cfg_data[MAP_W-1:0];
        CFG_STRIDE_1: stride1_r      <= cfg_data[ADDR_W-1:0];
        CFG_STRIDE_2: stride2_r      <= cfg_data[ADDR_W-1:0];
        CFG_STRIDE_3: stride3_r      <= cfg_data[ADDR_W-1:0];
        default: ;
      endcase
    end
  end

  assign c_ready   = !c_valid_r || out_tready;
  assign b_ready   = !b_valid_r || c_ready;
  assign a_ready   = !a_valid || b_ready;
  assign in_tready = a_ready;
  assign in_accept = in_tvalid && a_ready;

  tpag_walker u_walker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .load       (a_ready),
    .accept     (in_accept),
    .restart    (in_tdata[0]),
    .elem_valid (a_valid),
    .elem       (a_elem)
  );

  // stride multiply stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (b_ready) begin
      b_valid_r <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (b_ready && a_valid) begin
      b_r.dest    <= a_elem.dest;
      b_r.last_el <= a_elem.last_el;
      b_r.id0     <= ADDR_W'(a_elem.ids[0]);
      b_r.p1      <= ADDR_W'(a_elem.ids[1]) * stride1_r;
      b_r.p2      <= ADDR_W'(a_elem.ids[2]) * stride2_r;
      b_r.p3      <= ADDR_W'(a_elem.ids[3]) * stride3_r;
    end
  end

  // sum and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_valid_r <= 1'b0;
    end else if (c_ready) begin
      c_valid_r <= b_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (c_ready && b_valid_r) begin
      c_data_r <= {b_r.id0 + b_r.p1 + b_r.p2 + b_r.p3, b_r.dest};
      c_last_r <= b_r.last_el;
    end
  end

  assign out_tvalid = c_valid_r;
  assign out_tdata  = c_data_r;
  assign out_tlast  = c_last_r;

`ifndef ASSERT_OFF
  // an empty output register never blocks the input
  a_empty_out_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !c_valid_r |-> in_tready)
    else $error("in_tready low with empty output register");

  // a stalled multiply stage keeps its products
  a_b_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (b_valid_r && !b_ready) |=> (b_valid_r && $stable(b_r)))
    else $error("multiply stage lost data while stalled");

  // an element leaves the walker only when the next stage can take it or it waits
  a_a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (a_valid && !b_ready) |=> (a_valid && $stable(a_elem)))
    else $error("walker element changed while stalled");
`endif

endmodule

`default_nettype wire

// ----- dv/tb_tensor_permute_address_generator.sv -----
`timescale 1ns / 1ps

module tb_tensor_permute_address_generator;
  import tpag_pkg::*;

  localparam int ITEM_TARGET    = 1200;
  localparam int PRESSURE_ITEMS = 100;
  localparam int SETTLE_CYCLES  = 8;
  localparam int LONG_HOLD      = 300;
  localparam int IDLE_LIMIT     = 2000;

  localparam logic [AXES-1:0][CFG_IDX_W-1:0] SIZE_REGS =
    {CFG_SIZE_W, CFG_SIZE_Z, CFG_SIZE_Y, CFG_SIZE_X};
  localparam logic [3:1][CFG_IDX_W-1:0] STRIDE_REGS =
    {CFG_STRIDE_3, CFG_STRIDE_2, CFG_STRIDE_1};

  typedef enum int {READY_ALWAYS, READY_HALF, READY_SPARSE, READY_PERIODIC} ready_mode_e;

  typedef struct {
    logic [ADDR_W-1:0] dest;
    logic [ADDR_W-1:0] src;
    logic              last_el;
  } addr_pair_t;

  class permute_scoreboard;
    logic [SIZE_W-1:0]  extent_reg [AXES];
    logic [MAP_W-1:0]   axis_map;
    logic [ADDR_W-1:0]  stride [AXES];
    logic [COORD_W-1:0] coord [AXES];
    logic [ADDR_W-1:0]  dest_count;
    bit                 walk_done;
    addr_pair_t         pending_pairs [$];
    int                 produced;
    int                 mismatches;

    function new();
      foreach (coord[a]) begin
        extent_reg[a] = '0;
        stride[a]     = '0;
        coord[a]      = '0;
      end
      stride[0]  = 1;  // input axis 0 is always unit stride
      axis_map   = AXIS_MAP_RESET;
      dest_count = '0;
      walk_done  = 1'b1;
      produced   = 0;
      mismatches = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        CFG_SIZE_X:   extent_reg[0] = value[SIZE_W-1:0];
        CFG_SIZE_Y:   extent_reg[1] = value[SIZE_W-1:0];
        CFG_SIZE_Z:   extent_reg[2] = value[SIZE_W-1:0];
        CFG_SIZE_W:   extent_reg[3] = value[SIZE_W-1:0];
        CFG_AXIS_MAP: axis_map = value[MAP_W-1:0];
        CFG_STRIDE_1: stride[1] = value;
        CFG_STRIDE_2: stride[2] = value;
        CFG_STRIDE_3: stride[3] = value;
        default: ;
      endcase
    endfunction

    function void note_item(logic restart);
      int                 ext [AXES];
      logic [COORD_W-1:0] ids [AXES];
      logic [ADDR_W-1:0]  src;
      bit                 empty_shape;
      bit                 last_el;
      bit                 carry;
      int                 a;
      empty_shape = 1'b0;
      for (a = 0; a < AXES; a++) begin
        ext[a] = (extent_reg[a] > MAX_EXTENT) ? MAX_EXTENT : int'(extent_reg[a]);
        if (ext[a] == 0) empty_shape = 1'b1;
      end
      if (restart) begin
        for (a = 0; a < AXES; a++) coord[a] = '0;
        dest_count = '0;
        walk_done  = empty_shape;
      end
      if (walk_done || empty_shape) return;

      // lowest output axis wins, so route from the top down
      for (a = 0; a < AXES; a++) ids[a] = '0;
      for (a = AXES - 1; a >= 0; a--) ids[axis_map[2*a +: 2]] = coord[a];
      src = '0;
      for (a = 0; a < AXES; a++) src = src + ADDR_W'(ids[a]) * stride[a];

      last_el = 1'b1;
      for (a = 0; a < AXES; a++)
        if (int'(coord[a]) + 1 < ext[a]) last_el = 1'b0;

      pending_pairs.push_back('{dest: dest_count, src: src, last_el: last_el});
      produced++;
      dest_count = dest_count + 1'b1;

      if (last_el) begin
        walk_done = 1'b1;
        for (a = 0; a < AXES; a++) coord[a] = '0;
      end else begin
        // a coordinate at or past a shrunk extent counts as at its end
        carry = 1'b1;
        for (a = 0; a < AXES; a++) begin
          if (carry) begin
            if (int'(coord[a]) + 1 >= ext[a]) begin
              coord[a] = '0;
            end else begin
              coord[a] = coord[a] + 1'b1;
              carry    = 1'b0;
            end
          end
        end
      end
    endfunction

    task report(string what);
      mismatches++;
      $display("[%0t] mismatch: %s", $time, what);
    endtask

    task check_pair(logic [ADDR_W-1:0] dest, logic [ADDR_W-1:0] src, logic last_el);
      addr_pair_t want;
      if (pending_pairs.size() == 0) begin
        report($sformatf("unexpected result dest %h src %h last %b", dest, src, last_el));
        return;
      end
      want = pending_pairs.pop_front();
      if (dest !== want.dest)
        report($sformatf("dest_address got %h want %h", dest, want.dest));
      if (src !== want.src)
        report($sformatf("src_address got %h want %h (dest %h)", src, want.src, want.dest));
      if (last_el !== want.last_el)
        report($sformatf("final_element got %b want %b (dest %h)", last_el, want.last_el,
                         want.dest));
    endtask
  endclass

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tlast;
  logic                  cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_data   = '0;

  permute_scoreboard sb = new();
  int hold_requests = 0;
  int idle_cycles   = 0;
  int items_sent    = 0;

  tensor_permute_address_generator dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // handshake monitor and stall watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) sb.note_item(in_tdata[0]);
      if (out_tvalid && out_tready)
        sb.check_pair(out_tdata[ADDR_W-1:0], out_tdata[2*ADDR_W-1:ADDR_W], out_tlast);
    end
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin : receiver
    ready_mode_e mode;
    int          stretch;
    int          served;
    int          beat;
    mode    = READY_ALWAYS;
    stretch = 0;
    served  = 0;
    beat    = 0;
    forever begin
      if (served != hold_requests) begin
        // long hold-off: let the pipeline fill and back up the input
        served++;
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        if (stretch == 0) begin
          mode    = ready_mode_e'($urandom_range(0, 3));
          stretch = $urandom_range(10, 80);
        end
        stretch--;
        beat++;
        case (mode)
          READY_ALWAYS: out_tready <= 1'b1;
          READY_HALF:   out_tready <= ($urandom_range(0, 1) == 1);
          READY_SPARSE: out_tready <= ($urandom_range(0, 4) == 0);
          default:      out_tready <= (beat % 3 != 0);
        endcase
        @(posedge clk);
      end
    end
  end

  task automatic send_item(input logic restart);
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_DATA_W-1){1'b0}}, restart};
    items_sent++;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic sender_gap(input int cycles);
    in_tvalid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // hold the input until every result is back and the walker has settled
  task automatic drain;
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending_pairs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    sb.set_reg(idx, value);
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_stride();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return '1;
      2:       return $urandom_range(1, 64);
      default: return $urandom;
    endcase
  endfunction

  task automatic pick_config;
    int                    a;
    logic [CFG_DATA_W-1:0] value;
    for (a = 0; a < AXES; a++) begin
      if ($urandom_range(0, 3) != 0) begin
        case ($urandom_range(0, 15))
          0:       value = '0;
          1:       value = $urandom_range(MAX_EXTENT, 2**SIZE_W - 1);
          default: value = $urandom_range(1, 4);
        endcase
        write_reg(SIZE_REGS[a], value);
      end
    end
    if ($urandom_range(0, 3) != 0) write_reg(CFG_AXIS_MAP, $urandom_range(0, 255));
    for (a = 1; a < AXES; a++)
      if ($urandom_range(0, 3) != 0) write_reg(STRIDE_REGS[a], pick_stride());
    cfg_we <= 1'b0;
  endtask

  // odds of zero: one restart at the head, then a clean walk
  task automatic run_phase(input int n_items, input bit steady, input int odds);
    int   burst;
    int   i;
    logic restart;
    burst = $urandom_range(1, 40);
    for (i = 0; i < n_items; i++) begin
      if (burst == 0) begin
        if (!steady) sender_gap($urandom_range(1, 12));
        burst = $urandom_range(1, 40);
      end
      burst--;
      if (i == 0) restart = (odds == 0) || ($urandom_range(0, 1) == 1);
      else restart = (odds != 0) && ($urandom_range(0, odds) == 0);
      send_item(restart);
    end
  endtask

  initial begin : stimulus
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // idle after reset; a restart with zero sizes stays idle
    send_item(1'b0);
    send_item(1'b1);
    drain();

    write_reg(CFG_SIZE_X, 2);
    write_reg(CFG_SIZE_Y, 1);
    write_reg(CFG_SIZE_Z, 2);
    write_reg(CFG_SIZE_W, 1);
    write_reg(CFG_AXIS_MAP, CFG_DATA_W'(AXIS_MAP_RESET));
    write_reg(CFG_STRIDE_1, '1);
    write_reg(CFG_STRIDE_2, '1);
    write_reg(CFG_STRIDE_3, '1);
    cfg_we <= 1'b0;
    // first element comes on the restart item; one extra advance past the end
    send_item(1'b1);
    repeat (4) send_item(1'b0);
    drain();

    // every output axis reads input axis 0
    write_reg(CFG_AXIS_MAP, 32'h0000_0000);
    write_reg(CFG_SIZE_X, 3);
    write_reg(CFG_SIZE_Y, 2);
    write_reg(CFG_STRIDE_1, 32'h1234_5678);
    cfg_we <= 1'b0;
    send_item(1'b1);
    send_item(1'b0);
    send_item(1'b0);
    send_item(1'b1);
    send_item(1'b0);
    drain();

    // reversed map, then shrink x below the live coordinate
    write_reg(CFG_AXIS_MAP, 32'h0000_001B);
    write_reg(CFG_SIZE_X, 4);
    write_reg(CFG_SIZE_Z, 1);
    write_reg(CFG_STRIDE_1, 3);
    write_reg(CFG_STRIDE_2, 5);
    write_reg(CFG_STRIDE_3, 7);
    cfg_we <= 1'b0;
    send_item(1'b1);
    send_item(1'b0);
    send_item(1'b0);
    drain();
    write_reg(CFG_SIZE_X, 2);
    cfg_we <= 1'b0;
    send_item(1'b0);
    send_item(1'b0);
    drain();

    // a zero extent holds the walk in place
    write_reg(CFG_SIZE_W, 0);
    cfg_we <= 1'b0;
    send_item(1'b0);
    drain();
    write_reg(CFG_AXIS_MAP, 32'h0000_00FF);
    write_reg(CFG_SIZE_W, 1);
    cfg_we <= 1'b0;
    send_item(1'b0);

    // long receiver hold against a steady sender on a walk that always emits
    drain();
    write_reg(CFG_SIZE_X, 64);
    write_reg(CFG_SIZE_Y, 4);
    write_reg(CFG_SIZE_Z, 1);
    write_reg(CFG_SIZE_W, 1);
    cfg_we <= 1'b0;
    hold_requests++;
    run_phase(PRESSURE_ITEMS, 1'b1, 0);

    while (items_sent < ITEM_TARGET) begin
      drain();
      pick_config();
      run_phase($urandom_range(20, 150), ($urandom_range(0, 3) == 0),
                $urandom_range(4, 60));
    end

    drain();
    if (sb.mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/tpag_pkg.sv
rtl/core/tpag_walker.sv
rtl/core/tensor_permute_address_generator.sv
dv/tb_tensor_permute_address_generator.sv
